// File: design/w2s_pkg.sv
package w2s_pkg;

  localparam int NCOEFF     = 12;
  localparam int CIDX_W     = 4;
  localparam int ROW_STRIDE = 4;   // three weights and one offset per matrix row
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;
  localparam int WIDE       = 64;
  localparam int RATIO_BITS = 48;  // ratio magnitude is capped at 2**48
  localparam int DIM_W      = 14;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CIDX_W-1:0] COEFF_LIMIT   = 4'd12;
  localparam logic [DIM_W-1:0]  WIDTH_RESET   = 14'd1920;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET  = 14'd1080;

  typedef enum logic {
    OP_COEFF   = 1'b0,
    OP_PROJECT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVR_MODE    = 3'd0,
    CFG_OVR_WIDTH   = 3'd1,
    CFG_OVR_HEIGHT  = 3'd2,
    CFG_DISP_WIDTH  = 3'd3,
    CFG_DISP_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             ovr;
    logic [DIM_W-1:0] ovr_w;
    logic [DIM_W-1:0] ovr_h;
    logic [DIM_W-1:0] disp_w;
    logic [DIM_W-1:0] disp_h;
  } cfg_t;

  // queue entry: a holds the coefficient value or point x
  typedef struct packed {
    op_t                op;
    logic [CIDX_W-1:0]  cidx;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } qent_t;

  typedef struct packed {
    logic            wbad;
    logic [WIDE-1:0] d;
  } div_side_t;

  typedef struct packed {
    logic [WIDE-1:0]       n;
    logic [WIDE-1:0]       rem;
    logic [RATIO_BITS-1:0] q;
    logic                  cap;
    logic                  neg;
  } div_lane_t;

endpackage

// File: design/world_to_screen_projection.sv
// Throughput: one item per cycle while no result waits unpopped at the output; the divider
// is 48 pipelined restoring steps.
// Coefficient writes produce no result; in-range ones take one slot in the input queue.
// Reset (rst_n low, synchronous): queues empty, matrix cleared, size registers
// back to 1920x1080 with override mode off.
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_op,
  input  logic [3:0]                    in_coeff_index,
  input  logic signed [31:0]            in_coeff_value,
  input  logic signed [31:0]            in_point_x,
  input  logic signed [31:0]            in_point_y,
  input  logic signed [31:0]            in_point_z,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            out_screen_x,
  output logic signed [31:0]            out_screen_y,
  output logic                          out_rejected,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [w2s_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [w2s_pkg::DIM_W-1:0]     cfg_data
);

  w2s_pkg::cfg_t  cfg_r;
  logic           q_vld, q_pop;
  w2s_pkg::qent_t q_ent;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ovr    <= 1'b0;
      cfg_r.ovr_w  <= w2s_pkg::WIDTH_RESET;
      cfg_r.ovr_h  <= w2s_pkg::HEIGHT_RESET;
      cfg_r.disp_w <= w2s_pkg::WIDTH_RESET;
      cfg_r.disp_h <= w2s_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        w2s_pkg::CFG_OVR_MODE:    cfg_r.ovr    <= cfg_data[0];
        w2s_pkg::CFG_OVR_WIDTH:   cfg_r.ovr_w  <= cfg_data;
        w2s_pkg::CFG_OVR_HEIGHT:  cfg_r.ovr_h  <= cfg_data;
        w2s_pkg::CFG_DISP_WIDTH:  cfg_r.disp_w <= cfg_data;
        w2s_pkg::CFG_DISP_HEIGHT: cfg_r.disp_h <= cfg_data;
        default: ;
      endcase
    end
  end

  w2s_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .op          (in_op),
    .coeff_index (in_coeff_index),
    .coeff_value (in_coeff_value),
    .point_x     (in_point_x),
    .point_y     (in_point_y),
    .point_z     (in_point_z),
    .q_vld       (q_vld),
    .q_ent       (q_ent),
    .q_pop       (q_pop)
  );

  w2s_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_ent    (q_ent),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .pop      (pop),
    .empty    (empty),
    .screen_x (out_screen_x),
    .screen_y (out_screen_y),
    .rejected (out_rejected)
  );

endmodule

// File: design/w2s_front.sv
module w2s_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       op,
  input  logic [w2s_pkg::CIDX_W-1:0] coeff_index,
  input  logic signed [31:0]         coeff_value,
  input  logic signed [31:0]         point_x,
  input  logic signed [31:0]         point_y,
  input  logic signed [31:0]         point_z,
  output logic                       q_vld,
  output w2s_pkg::qent_t             q_ent,
  input  logic                       q_pop
);

  localparam int QD  = w2s_pkg::QDEPTH;
  localparam int QAW = w2s_pkg::QAW;

  w2s_pkg::qent_t   mem_r [QD];
  w2s_pkg::qent_t   ent;
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             keep, wr, rd;

  // writes to coefficients beyond the matrix are dropped here
  assign keep = (op == w2s_pkg::OP_PROJECT) || (coeff_index < w2s_pkg::COEFF_LIMIT);
  assign full = (cnt_r == (QAW+1)'(QD));
  assign wr   = push && !full && keep;
  assign rd   = q_pop && q_vld;

  always_comb begin
    ent.op   = w2s_pkg::op_t'(op);
    ent.cidx = coeff_index;
    ent.a    = (op == w2s_pkg::OP_PROJECT) ? point_x : coeff_value;
    ent.b    = point_y;
    ent.c    = point_z;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end

  assign q_vld = (cnt_r != '0);
  assign q_ent = mem_r[rd_ptr_r];

endmodule

// File: design/w2s_divstep.sv
module w2s_divstep #(
  parameter int BIT       = 0,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  w2s_pkg::div_side_t    side_i,
  input  w2s_pkg::div_lane_t    x_i,
  input  w2s_pkg::div_lane_t    y_i,
  output logic                  vld_o,
  output w2s_pkg::div_side_t    side_o,
  output w2s_pkg::div_lane_t    x_o,
  output w2s_pkg::div_lane_t    y_o
);

  localparam int  W     = w2s_pkg::WIDE;
  localparam int  QB    = w2s_pkg::RATIO_BITS;
  localparam bit  HAS_N = (BIT >= FRAC_BITS);
  localparam int  NIDX  = HAS_N ? (BIT - FRAC_BITS) : 0;

  logic               vld_r;
  w2s_pkg::div_side_t side_r;
  w2s_pkg::div_lane_t x_r, y_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic w2s_pkg::div_lane_t step(w2s_pkg::div_lane_t l, logic [W-1:0] d);
    w2s_pkg::div_lane_t r;
    logic [W:0]         trial;
    logic               nbit;
    logic               fits;
    r     = l;
    nbit  = HAS_N ? l.n[NIDX] : 1'b0;
    trial = {l.rem, nbit};
    fits  = (trial >= {1'b0, d});
    r.rem = fits ? W'(trial - {1'b0, d}) : trial[W-1:0];
    r.q   = {l.q[QB-2:0], fits};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      x_r    <= step(x_i, side_i.d);
      y_r    <= step(y_i, side_i.d);
    end
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;

endmodule

// File: design/w2s_back.sv
module w2s_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  w2s_pkg::qent_t      q_ent,
  output logic                q_pop,
  input  w2s_pkg::cfg_t       cfg,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  screen_x,
  output logic signed [31:0]  screen_y,
  output logic                rejected
);

  localparam int W         = w2s_pkg::WIDE;
  localparam int QB        = w2s_pkg::RATIO_BITS;
  localparam int MW        = QB + 1;
  localparam int TW        = QB + 2;
  localparam int CAP_SHIFT = QB - FRAC_BITS;
  localparam int NC        = w2s_pkg::NCOEFF;
  localparam int RS        = w2s_pkg::ROW_STRIDE;
  localparam int DW        = w2s_pkg::DIM_W;
  localparam logic signed [W-1:0] ONE     = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] S32_MAX = (W'(1) << 31) - W'(1);
  localparam logic signed [W-1:0] S32_MIN = -(W'(1) << 31);

  logic en;
  logic out_v_r;

  // whole back pipeline moves together; it only holds while a result waits
  assign en    = !out_v_r || pop;
  assign q_pop = en && q_vld;

  // ---- matrix, product stage ----
  logic signed [31:0]  coef_r [NC];
  logic signed [31:0]  pt [3];
  logic signed [W-1:0] prod_r [3][3];
  logic signed [31:0]  off_r [3];
  logic                p_v_r;

  assign pt[0] = q_ent.a;
  assign pt[1] = q_ent.b;
  assign pt[2] = q_ent.c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        coef_r[i] <= '0;
      end
    end else if (q_pop && q_ent.op == w2s_pkg::OP_COEFF) begin
      coef_r[q_ent.cidx] <= q_ent.a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= q_pop && (q_ent.op == w2s_pkg::OP_PROJECT);
    end
  end

  // rows: w, x, y
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= coef_r[r*RS + c] * pt[c];
        end
        off_r[r] <= coef_r[r*RS + 3];
      end
    end
  end

  // ---- floor shift and sum ----
  logic signed [W-1:0] acc_r [3];
  logic                s_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (en) begin
      s_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc_r[r] <= (prod_r[r][0] >>> FRAC_BITS) + (prod_r[r][1] >>> FRAC_BITS)
                  + (prod_r[r][2] >>> FRAC_BITS) + W'(off_r[r]);
      end
    end
  end

  // ---- divider setup: magnitudes, cap test, integer part of the remainder ----
  w2s_pkg::div_side_t side_nxt, side_c [QB+1];
  w2s_pkg::div_lane_t x_nxt, y_nxt, x_c [QB+1], y_c [QB+1];
  logic               v_c [QB+1];
  logic               prep_v_r;
  w2s_pkg::div_side_t prep_side_r;
  w2s_pkg::div_lane_t prep_x_r, prep_y_r;

  function automatic w2s_pkg::div_lane_t setup(logic signed [W-1:0] num, logic [W-1:0] d);
    w2s_pkg::div_lane_t l;
    logic [W-1:0]       mag;
    logic [W-1:0]       hi;
    mag   = num[W-1] ? W'(-num) : W'(num);
    hi    = mag >> CAP_SHIFT;
    l.n   = mag;
    l.rem = hi;
    l.q   = '0;
    l.cap = (hi >= d);
    l.neg = num[W-1];
    return l;
  endfunction

  always_comb begin
    side_nxt.wbad = (acc_r[0] < ONE);
    side_nxt.d    = acc_r[0];
    x_nxt         = setup(acc_r[1], acc_r[0]);
    y_nxt         = setup(acc_r[2], acc_r[0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (en) begin
      prep_v_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_side_r <= side_nxt;
      prep_x_r    <= x_nxt;
      prep_y_r    <= y_nxt;
    end
  end

  assign v_c[0]    = prep_v_r;
  assign side_c[0] = prep_side_r;
  assign x_c[0]    = prep_x_r;
  assign y_c[0]    = prep_y_r;

  for (genvar i = 0; i < QB; i++) begin : g_div
    w2s_divstep #(
      .BIT       (QB - 1 - i),
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (v_c[i]),
      .side_i (side_c[i]),
      .x_i    (x_c[i]),
      .y_i    (y_c[i]),
      .vld_o  (v_c[i+1]),
      .side_o (side_c[i+1]),
      .x_o    (x_c[i+1]),
      .y_o    (y_c[i+1])
    );
  end

  // ---- scale to pixels ----
  function automatic logic signed [TW-1:0] ratio_of(w2s_pkg::div_lane_t l);
    logic [MW-1:0] mag;
    mag = l.cap ? (MW'(1) << QB) : {1'b0, l.q};
    return l.neg ? -$signed(TW'(mag)) : $signed(TW'(mag));
  endfunction

  logic [DW-1:0]        wid, hei;
  logic [DW-2:0]        half_w, half_h;
  logic signed [TW-1:0] term_x, term_y;
  logic signed [W-1:0]  m_sx_r, m_sy_r;
  logic                 m_wbad_r, m_v_r;

  assign wid    = cfg.ovr ? cfg.ovr_w : cfg.disp_w;
  assign hei    = cfg.ovr ? cfg.ovr_h : cfg.disp_h;
  assign half_w = wid[DW-1:1];
  assign half_h = hei[DW-1:1];
  assign term_x = TW'(ONE) + ratio_of(x_c[QB]);
  assign term_y = TW'(ONE) - ratio_of(y_c[QB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= v_c[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_wbad_r <= side_c[QB].wbad;
      m_sx_r   <= $signed({1'b0, half_w}) * term_x;
      m_sy_r   <= $signed({1'b0, half_h}) * term_y;
    end
  end

  // ---- clip, saturate, result register ----
  function automatic logic signed [31:0] sat32(logic signed [W-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic signed [W-1:0] lim_w, lim_h;
  logic                clip, rej;
  logic signed [31:0]  sx_out_r, sy_out_r;
  logic                rej_out_r;

  assign lim_w = W'(wid) << FRAC_BITS;
  assign lim_h = W'(hei) << FRAC_BITS;
  // clip test sees the unsaturated values
  assign clip  = !cfg.ovr && (m_sx_r > lim_w || m_sy_r > lim_h || m_sx_r < 0 || m_sy_r < 0);
  assign rej   = m_wbad_r || clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_out_r  <= rej ? '0 : sat32(m_sx_r);
      sy_out_r  <= rej ? '0 : sat32(m_sy_r);
      rej_out_r <= rej;
    end
  end

  assign empty    = !out_v_r;
  assign screen_x = sx_out_r;
  assign screen_y = sy_out_r;
  assign rejected = rej_out_r;

endmodule

// File: design/w2s_checker.sv
module w2s_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          push,
  input logic                          full,
  input logic                          in_op,
  input logic [3:0]                    in_coeff_index,
  input logic signed [31:0]            in_coeff_value,
  input logic signed [31:0]            in_point_x,
  input logic signed [31:0]            in_point_y,
  input logic signed [31:0]            in_point_z,
  input logic                          empty,
  input logic                          pop,
  input logic signed [31:0]            out_screen_x,
  input logic signed [31:0]            out_screen_y,
  input logic                          out_rejected,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [w2s_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [w2s_pkg::DIM_W-1:0]     cfg_data
);

  // a waiting beat stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_screen_x) && $stable(out_screen_y)
                       && $stable(out_rejected))
    else $error("result beat changed while stalled");

  // rejected points always report the origin
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_rejected |-> out_screen_x == 0 && out_screen_y == 0)
    else $error("rejected result with nonzero coordinates");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (.*);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES = 12;

  typedef struct {
    w2s_pkg::op_t       op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    bit                 typed;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic               erej;
  } beat_t;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               rej;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic in_op = 1'b0;
  logic [3:0] in_coeff_index = '0;
  logic signed [31:0] in_coeff_value = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] out_screen_x;
  logic signed [31:0] out_screen_y;
  logic out_rejected;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [w2s_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [w2s_pkg::DIM_W-1:0] cfg_data = '0;

  world_to_screen_projection dut (.*);

  always #5 clk = ~clk;

  // shadow of the block's state
  logic signed [31:0] view_mat [w2s_pkg::NCOEFF];
  logic        sh_ovr;
  logic [13:0] sh_ovr_w, sh_ovr_h, sh_disp_w, sh_disp_h;

  pixel_t pending_pixels[$];
  int errors = 0;
  int pop_hold = 0;
  bit pop_steady = 0;

  function automatic longint row_dot(int base, logic signed [31:0] px,
                                     logic signed [31:0] py, logic signed [31:0] pz);
    longint acc;
    acc = (longint'(view_mat[base]) * longint'(px)) >>> FRAC;
    acc += (longint'(view_mat[base + 1]) * longint'(py)) >>> FRAC;
    acc += (longint'(view_mat[base + 2]) * longint'(pz)) >>> FRAC;
    return acc + longint'(view_mat[base + 3]);
  endfunction

  // Q-form quotient, truncated toward zero, magnitude capped at 2^48
  function automatic longint q_ratio(longint num, longint w);
    logic [127:0] n, d, q;
    bit neg;
    neg = num < 0;
    n = 128'(neg ? -num : num);
    d = 128'(w);
    if (n / d >= (128'd1 << (48 - FRAC))) q = 128'd1 << 48;
    else q = (n << FRAC) / d;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic pixel_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                           logic signed [31:0] pz);
    longint w, x, y, sx, sy;
    longint wid, hei;
    pixel_t r;
    r = '{sx: '0, sy: '0, rej: 1'b1};
    w = row_dot(0, px, py, pz);
    if (w < ONE) return r;
    x = row_dot(4, px, py, pz);
    y = row_dot(8, px, py, pz);
    wid = sh_ovr ? longint'(sh_ovr_w) : longint'(sh_disp_w);
    hei = sh_ovr ? longint'(sh_ovr_h) : longint'(sh_disp_h);
    sx = (wid / 2) * (ONE + q_ratio(x, w));
    sy = (hei / 2) * (ONE - q_ratio(y, w));
    if (!sh_ovr && (sx > wid * ONE || sy > hei * ONE || sx < 0 || sy < 0)) return r;
    r.sx = clamp32(sx);
    r.sy = clamp32(sy);
    r.rej = 1'b0;
    return r;
  endfunction

  task automatic send_beat(beat_t b);
    pixel_t p;
    @(negedge clk);
    push <= 1'b1;
    in_op <= b.op;
    in_coeff_index <= b.idx;
    in_coeff_value <= b.val;
    in_point_x <= b.px;
    in_point_y <= b.py;
    in_point_z <= b.pz;
    do @(posedge clk); while (full);
    if (b.op == w2s_pkg::OP_COEFF) begin
      if (b.idx < w2s_pkg::COEFF_LIMIT) view_mat[b.idx] = b.val;
    end else if (b.typed) begin
      pending_pixels.push_back('{sx: b.ex, sy: b.ey, rej: b.erej});
    end else begin
      p = project_point(b.px, b.py, b.pz);
      pending_pixels.push_back(p);
    end
  endtask

  task automatic idle_sender(int gap);
    @(negedge clk);
    push <= 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(w2s_pkg::cfg_reg_t r, logic [13:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      w2s_pkg::CFG_OVR_MODE:    sh_ovr = v[0];
      w2s_pkg::CFG_OVR_WIDTH:   sh_ovr_w = v;
      w2s_pkg::CFG_OVR_HEIGHT:  sh_ovr_h = v;
      w2s_pkg::CFG_DISP_WIDTH:  sh_disp_w = v;
      w2s_pkg::CFG_DISP_HEIGHT: sh_disp_h = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] any32();
    return $urandom();
  endfunction

  function automatic logic signed [31:0] near32(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [13:0] pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 14'd0;
    if (r == 1) return 14'd1;
    if (r == 2) return 14'd8192;
    if (r == 3) return 14'h3fff;
    return 14'($urandom_range(2, 8191));
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int r;
    b = '{op: w2s_pkg::OP_PROJECT, idx: '0, val: '0, px: '0, py: '0, pz: '0,
          typed: 0, ex: '0, ey: '0, erej: 1'b0};
    r = $urandom_range(0, 99);
    if (r < 15) begin
      b.op = w2s_pkg::OP_COEFF;
      b.idx = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 11));
      b.val = ($urandom_range(0, 4) == 0) ? any32() : near32(1 << 18);
      if (b.idx == 3 && $urandom_range(0, 3) != 0) b.val = $urandom_range(1 << 16, 1 << 21);
      b.px = any32();
    end else if (r < 25) begin
      b.px = any32();
      b.py = any32();
      b.pz = any32();
      b.val = any32();
      b.idx = 4'($urandom_range(0, 15));
    end else begin
      b.px = near32(1 << 22);
      b.py = near32(1 << 22);
      b.pz = near32(1 << 22);
    end
    return b;
  endfunction

  beat_t opening_rows[] = '{
    // all-zero matrix: w below one, behind camera
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1, 32'sd0, 32'sd0, 1'b1},
    '{w2s_pkg::OP_COEFF, 4'd3, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    // w = 1, x = y = 0: screen center
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
      1, 32'sd62914560, 32'sd35389440, 1'b0},
    // out-of-range indexes are dropped
    '{w2s_pkg::OP_COEFF, 4'd15, 32'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd12, 32'hffffffff, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      1, 32'sd62914560, 32'sd35389440, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'h80000000, 32'h80000000, 32'h80000000,
      1, 32'sd62914560, 32'sd35389440, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd4, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd9, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'h80000000, 32'sd0, 32'sd0,
      1, 32'sd0, 32'sd0, 1'b1},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'h7fffffff, 32'h7fffffff, 32'sd0,
      0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'h80000000, 32'sd0,
      0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd11, 32'h80000000, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd7, 32'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd1, 32'h12345678, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd2, 32'hffff0000, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd5, 32'h00008000, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd6, 32'hedcba987, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd8, 32'h7fffffff, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_COEFF, 4'd10, 32'h80000000, 32'sd0, 32'sd0, 32'sd0, 0, 32'sd0, 32'sd0, 1'b0},
    '{w2s_pkg::OP_PROJECT, 4'd0, 32'sd0, 32'h00010000, 32'hffff0000, 32'h00020000,
      0, 32'sd0, 32'sd0, 1'b0}
  };

  // size settings walked by the first phases; the rest are random
  logic [13:0] size_set [5][5] = '{
    '{14'd1, 14'd1, 14'd1, 14'd1, 14'd1},
    '{14'd1, 14'd8192, 14'd8192, 14'd8192, 14'd8192},
    '{14'd0, 14'd0, 14'd0, 14'd0, 14'd0},
    '{14'd0, 14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff},
    '{14'd1, 14'h3fff, 14'd0, 14'd2, 14'd3}
  };

  // result side: random pop with an occasional long hold-off
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (pop_steady) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
      if ($urandom_range(0, 99) < 2) pop_hold <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat: screen_x=%0d screen_y=%0d rejected=%0b",
               out_screen_x, out_screen_y, out_rejected);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_screen_x !== e.sx) begin
          $error("screen_x: expected %0d, got %0d", e.sx, out_screen_x);
          errors++;
        end
        if (out_screen_y !== e.sy) begin
          $error("screen_y: expected %0d, got %0d", e.sy, out_screen_y);
          errors++;
        end
        if (out_rejected !== e.rej) begin
          $error("rejected: expected %0b, got %0b", e.rej, out_rejected);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    beat_t b;
    int n;
    foreach (view_mat[i]) view_mat[i] = '0;
    sh_ovr = 1'b0;
    sh_ovr_w = 14'd1920;
    sh_ovr_h = 14'd1080;
    sh_disp_w = 14'd1920;
    sh_disp_h = 14'd1080;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      send_beat(opening_rows[i]);
      if ($urandom_range(0, 3) == 0) idle_sender(pick_gap());
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        if (ph <= 5) begin
          write_reg(w2s_pkg::CFG_OVR_MODE, size_set[ph - 1][0]);
          write_reg(w2s_pkg::CFG_OVR_WIDTH, size_set[ph - 1][1]);
          write_reg(w2s_pkg::CFG_OVR_HEIGHT, size_set[ph - 1][2]);
          write_reg(w2s_pkg::CFG_DISP_WIDTH, size_set[ph - 1][3]);
          write_reg(w2s_pkg::CFG_DISP_HEIGHT, size_set[ph - 1][4]);
        end else begin
          write_reg(w2s_pkg::CFG_OVR_MODE, 14'($urandom_range(0, 1)));
          write_reg(w2s_pkg::CFG_OVR_WIDTH, pick_dim());
          write_reg(w2s_pkg::CFG_OVR_HEIGHT, pick_dim());
          write_reg(w2s_pkg::CFG_DISP_WIDTH, pick_dim());
          write_reg(w2s_pkg::CFG_DISP_HEIGHT, pick_dim());
        end
      end
      // a sane camera first: positive depth offset, modest weights
      for (int k = 0; k < w2s_pkg::NCOEFF; k++) begin
        b = rand_beat();
        b.op = w2s_pkg::OP_COEFF;
        b.idx = 4'(k);
        b.val = (k == 3) ? $urandom_range(1 << 16, 1 << 22) : near32(1 << 17);
        send_beat(b);
      end
      pop_steady = (ph == 2);
      if (ph == 4) pop_hold = 300;  // receiver stalls, sender keeps pushing
      // the stalled phase offers more beats than the pipeline and queue can hold
      n = (ph == 0) ? 20 : (ph == 4) ? 80 : 18;
      for (int k = 0; k < n; k++) begin
        send_beat(rand_beat());
        if (ph != 2 && ph != 4) idle_sender(pick_gap());
      end
      drain();
    end

    pop_steady = 0;
    drain();
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
